// ===== rtl/pwrf_pkg.sv =====
package pwrf_pkg;

  localparam int DEPTH    = 64;
  localparam int FILL_W   = $clog2(DEPTH + 1);
  localparam int MASS_W   = 32;
  localparam int INT_W    = 32;
  localparam int CNT_W    = 4;
  localparam int GRP_SIZE = 8;
  localparam int GRP_CNT  = DEPTH / GRP_SIZE;
  localparam int GRP_W    = $clog2(GRP_SIZE + 1);
  localparam int SUM_W    = $clog2(DEPTH + 1);

  localparam logic CFG_HALF_WINDOW = 1'b0;
  localparam logic CFG_KEEP_COUNT  = 1'b1;

  typedef struct packed {
    logic [MASS_W-1:0]        mass;
    logic signed [INT_W-1:0]  inten;
    logic [CNT_W-1:0]         cnt;
    logic                     valid;
  } cell_data_t;

  // new peak and window settings, broadcast to every cell
  typedef struct packed {
    logic [MASS_W-1:0]        mass;
    logic signed [INT_W-1:0]  inten;
    logic [MASS_W:0]          mass_ph;
    logic [MASS_W-1:0]        half;
    logic [CNT_W-1:0]         keep;
    logic [CNT_W-1:0]         newcnt;
  } bcast_t;

  typedef struct packed {
    logic shift;
    logic cmp;
  } cell_ctl_t;

endpackage

// ===== rtl/peak_window_rank_filter_top.sv =====
// Sliding-window peak filter. Peaks of one spectrum enter on the in_ channel
// (valid/stall) in nondecreasing mass order; each retired peak leaves on the
// out_ channel with its keep flag, an overflow flag when the store was full,
// and last_result on the final peak of a spectrum marked by in_last_peak.
// Peaks wait in a row of 64 cells that shift towards the head as the oldest
// one retires; the new peak is compared with every cell at once.
// Per peak: accept, retire head peaks out of the new peak's window, compare,
// insert, then flush all held peaks on the last peak (or emit the single
// overflow beat). The count tree registers group counts between compare and
// insert; the head emits one beat per cycle unless out_stall holds it.
// in_stall is high from acceptance until the peak's work is done. The output
// register holds a beat while out_stall is high and the block waits for it
// to free before emitting the next. cfg_we writes half_window (index 0) or
// keep_count (index 1); the user writes only while the block is idle, which
// the block does not enforce. Synchronous reset (rst_n low) empties the
// window store and restores half_window to 25.0 and keep_count to 7.
module peak_window_rank_filter_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [31:0]               in_peak_mass,
  input  logic signed [31:0]        in_peak_intensity,
  input  logic                      in_last_peak,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [31:0]               out_mass,
  output logic signed [31:0]        out_intensity,
  output logic                      out_keep,
  output logic                      out_overflow,
  output logic                      out_last_result,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [31:0]               cfg_data
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RETIRE = 3'd1;
  localparam logic [2:0] ST_CMP    = 3'd2;
  localparam logic [2:0] ST_INS    = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;

  logic [2:0]                      state_r, state_nxt;
  logic [pwrf_pkg::FILL_W-1:0]     fill_r, fill_nxt;
  logic [31:0]                     half_r;
  logic [pwrf_pkg::CNT_W-1:0]      keep_r;
  logic [31:0]                     mass_r;
  logic signed [31:0]              inten_r;
  logic                            last_r;
  logic                            out_valid_r, out_valid_nxt;
  logic [31:0]                     out_mass_r;
  logic signed [31:0]              out_inten_r;
  logic                            out_keep_r, out_ovf_r, out_last_r;
  logic                            out_free, emit, emit_ovf, emit_last, retire_due, ins;
  logic                            in_accept;

  pwrf_pkg::cell_data_t            cell_q [pwrf_pkg::DEPTH];
  pwrf_pkg::cell_data_t            head;
  logic [pwrf_pkg::DEPTH-1:0]      stronger;
  pwrf_pkg::cell_ctl_t             ctl;
  pwrf_pkg::bcast_t                bc;
  logic [pwrf_pkg::CNT_W-1:0]      newcnt;

  assign head      = cell_q[0];
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign bc.mass    = mass_r;
  assign bc.inten   = inten_r;
  assign bc.mass_ph = {1'b0, mass_r} + {1'b0, half_r};
  assign bc.half    = half_r;
  assign bc.keep    = keep_r;
  assign bc.newcnt  = newcnt;

  assign retire_due = (fill_r != '0) && ({1'b0, mass_r} > ({1'b0, head.mass} + {1'b0, half_r}));

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    emit      = 1'b0;
    emit_ovf  = 1'b0;
    emit_last = 1'b0;
    ins       = 1'b0;
    ctl.cmp   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) state_nxt = ST_RETIRE;
      end
      ST_RETIRE: begin
        if (!retire_due) begin
          state_nxt = ST_CMP;
        end else if (out_free) begin
          emit     = 1'b1;
          fill_nxt = fill_r - pwrf_pkg::FILL_W'(1);
        end
      end
      ST_CMP: begin
        ctl.cmp   = 1'b1;
        state_nxt = ST_INS;
      end
      ST_INS: begin
        ins      = 1'b1;
        fill_nxt = fill_r + pwrf_pkg::FILL_W'(1);
        if (last_r || (fill_nxt == pwrf_pkg::FILL_W'(pwrf_pkg::DEPTH))) begin
          state_nxt = ST_DRAIN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_ovf  = !last_r;
          emit_last = last_r && (fill_r == pwrf_pkg::FILL_W'(1));
          fill_nxt  = fill_r - pwrf_pkg::FILL_W'(1);
          if (!last_r || (fill_r == pwrf_pkg::FILL_W'(1))) state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    ctl.shift = emit;
  end

  for (genvar i = 0; i < pwrf_pkg::DEPTH; i++) begin : g_cell
    pwrf_pkg::cell_data_t up;
    if (i == pwrf_pkg::DEPTH - 1) begin : g_tail
      assign up = '0;
    end else begin : g_mid
      assign up = cell_q[i+1];
    end
    pwrf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .load     (ins && (fill_r == pwrf_pkg::FILL_W'(i))),
      .bc       (bc),
      .up       (up),
      .q        (cell_q[i]),
      .stronger (stronger[i])
    );
  end

  pwrf_count u_count (
    .clk      (clk),
    .stronger (stronger),
    .keep     (keep_r),
    .newcnt   (newcnt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      half_r      <= 32'd1638400;
      keep_r      <= pwrf_pkg::CNT_W'(7);
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          pwrf_pkg::CFG_HALF_WINDOW: half_r <= cfg_data;
          pwrf_pkg::CFG_KEEP_COUNT:  keep_r <= cfg_data[pwrf_pkg::CNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mass_r  <= in_peak_mass;
      inten_r <= in_peak_intensity;
      last_r  <= in_last_peak;
    end
    if (emit) begin
      out_mass_r  <= head.mass;
      out_inten_r <= head.inten;
      out_keep_r  <= ($signed(head.inten) > 32'sd0) && (head.cnt < keep_r);
      out_ovf_r   <= emit_ovf;
      out_last_r  <= emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_mass        = out_mass_r;
  assign out_intensity   = out_inten_r;
  assign out_keep        = out_keep_r;
  assign out_overflow    = out_ovf_r;
  assign out_last_result = out_last_r;

endmodule

// ===== rtl/pwrf_cell.sv =====
module pwrf_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pwrf_pkg::cell_ctl_t   ctl,
  input  logic                  load,
  input  pwrf_pkg::bcast_t      bc,
  input  pwrf_pkg::cell_data_t  up,
  output pwrf_pkg::cell_data_t  q,
  output logic                  stronger
);

  pwrf_pkg::cell_data_t        data_r, data_nxt;
  logic [pwrf_pkg::MASS_W:0]   mass33, mass_ph, new33;
  logic                        win_new, win_cell, bump;

  assign mass33  = {1'b0, data_r.mass};
  assign mass_ph = mass33 + {1'b0, bc.half};
  assign new33   = {1'b0, bc.mass};

  // cell inside the new peak's window: m - h < x <= m + h
  assign win_new  = data_r.valid && (mass_ph > new33) && (mass33 <= bc.mass_ph);
  // new peak inside this cell's window: x - h < m <= x + h
  assign win_cell = data_r.valid && (bc.mass_ph > mass33) && (new33 <= mass_ph);

  assign stronger = win_new && ($signed(data_r.inten) > $signed(bc.inten));
  assign bump     = ctl.cmp && win_cell && ($signed(bc.inten) > $signed(data_r.inten))
                    && (data_r.cnt < bc.keep);

  always_comb begin
    data_nxt = data_r;
    if (ctl.shift) begin
      data_nxt = up;
    end else if (load) begin
      data_nxt.mass  = bc.mass;
      data_nxt.inten = bc.inten;
      data_nxt.cnt   = bc.newcnt;
      data_nxt.valid = 1'b1;
    end else if (bump) begin
      data_nxt.cnt = data_r.cnt + pwrf_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    data_r.mass  <= data_nxt.mass;
    data_r.inten <= data_nxt.inten;
    if (!rst_n) begin
      data_r.cnt   <= '0;
      data_r.valid <= 1'b0;
    end else begin
      data_r.cnt   <= data_nxt.cnt;
      data_r.valid <= data_nxt.valid;
    end
  end

  assign q = data_r;

endmodule

// ===== rtl/pwrf_count.sv =====
module pwrf_count (
  input  logic                         clk,
  input  logic [pwrf_pkg::DEPTH-1:0]   stronger,
  input  logic [pwrf_pkg::CNT_W-1:0]   keep,
  output logic [pwrf_pkg::CNT_W-1:0]   newcnt
);

  logic [pwrf_pkg::GRP_W-1:0] grp_r   [pwrf_pkg::GRP_CNT];
  logic [pwrf_pkg::GRP_W-1:0] grp_nxt [pwrf_pkg::GRP_CNT];
  logic [pwrf_pkg::SUM_W-1:0] total;

  // first level: one population count per group of cells
  always_comb begin
    for (int g = 0; g < pwrf_pkg::GRP_CNT; g++) begin
      grp_nxt[g] = '0;
      for (int b = 0; b < pwrf_pkg::GRP_SIZE; b++) begin
        grp_nxt[g] = grp_nxt[g]
                     + pwrf_pkg::GRP_W'(stronger[g*pwrf_pkg::GRP_SIZE + b]);
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

  // second level: add the groups and saturate at keep_count
  always_comb begin
    total = '0;
    for (int g = 0; g < pwrf_pkg::GRP_CNT; g++) begin
      total = total + pwrf_pkg::SUM_W'(grp_r[g]);
    end
  end

  assign newcnt = (total > pwrf_pkg::SUM_W'(keep)) ? keep : total[pwrf_pkg::CNT_W-1:0];

endmodule

// ===== tb/peak_window_rank_filter_top_test.sv =====
`timescale 1ns / 100ps

module peak_window_rank_filter_top_test;

  localparam int    CYCLE_LIMIT = 2000000;
  localparam int    SETTLE_CYCLES = 32;
  localparam longint MASS_TOP = 64'h0000_0000_FFFF_FFFF;

  typedef struct {
    logic [pwrf_pkg::MASS_W-1:0]       mass;
    logic signed [pwrf_pkg::INT_W-1:0] inten;
    logic [pwrf_pkg::CNT_W-1:0]        stronger;
  } held_peak_t;

  typedef struct {
    logic [pwrf_pkg::MASS_W-1:0]       mass;
    logic signed [pwrf_pkg::INT_W-1:0] inten;
    logic                              keep;
    logic                              overflow;
    logic                              last;
  } retired_peak_t;

  typedef struct {
    logic [pwrf_pkg::MASS_W-1:0]       mass;
    logic signed [pwrf_pkg::INT_W-1:0] inten;
    logic                              last;
    bit                                typed;
    retired_peak_t                     want;
  } stim_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [31:0]             in_peak_mass;
  logic signed [31:0]      in_peak_intensity;
  logic                    in_last_peak;
  logic                    out_valid;
  logic                    out_stall;
  logic [31:0]             out_mass;
  logic signed [31:0]      out_intensity;
  logic                    out_keep;
  logic                    out_overflow;
  logic                    out_last_result;
  logic                    cfg_we;
  logic                    cfg_index;
  logic [31:0]             cfg_data;

  // window store as the block should hold it, oldest peak first
  held_peak_t    held_peaks[$];
  retired_peak_t pending_beats[$];
  stim_row_t     stim_rows[$];

  logic [31:0]                half_cfg = 32'd1638400;
  logic [pwrf_pkg::CNT_W-1:0] keep_cfg = 4'd7;

  bit            typed_now = 1'b0;
  retired_peak_t typed_beat;
  bit            in_burst = 1'b0;
  bit            out_burst = 1'b0;
  int            errors = 0;
  int            cycles = 0;

  peak_window_rank_filter_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_peak_mass      (in_peak_mass),
    .in_peak_intensity (in_peak_intensity),
    .in_last_peak      (in_last_peak),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_mass          (out_mass),
    .out_intensity     (out_intensity),
    .out_keep          (out_keep),
    .out_overflow      (out_overflow),
    .out_last_result   (out_last_result),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [pwrf_pkg::CNT_W-1:0] bump(input logic [pwrf_pkg::CNT_W-1:0] c);
    return (c < keep_cfg) ? c + 1'b1 : c;
  endfunction

  function automatic void retire_oldest(input logic ovf, input logic lst);
    retired_peak_t r;
    r.mass     = held_peaks[0].mass;
    r.inten    = held_peaks[0].inten;
    r.keep     = (held_peaks[0].inten > 0) && (held_peaks[0].stronger < keep_cfg);
    r.overflow = ovf;
    r.last     = lst;
    pending_beats.insert(pending_beats.size(), r);
    void'(held_peaks.pop_front());
  endfunction

  function automatic void rank_peak(input logic [pwrf_pkg::MASS_W-1:0] m,
                                    input logic signed [pwrf_pkg::INT_W-1:0] p,
                                    input logic lst);
    longint     lm;
    longint     lh;
    longint     cm;
    held_peak_t fresh;
    lm = m;
    lh = half_cfg;
    fresh.mass     = m;
    fresh.inten    = p;
    fresh.stronger = '0;
    // retire from the head only, so a stray low mass holds up the rest
    while (held_peaks.size() > 0) begin
      cm = held_peaks[0].mass;
      if (lm <= cm + lh)
        break;
      retire_oldest(1'b0, 1'b0);
    end
    foreach (held_peaks[k]) begin
      cm = held_peaks[k].mass;
      if (cm > lm - lh && cm <= lm + lh && held_peaks[k].inten > p)
        fresh.stronger = bump(fresh.stronger);
      if (lm > cm - lh && lm <= cm + lh && p > held_peaks[k].inten)
        held_peaks[k].stronger = bump(held_peaks[k].stronger);
    end
    held_peaks.insert(held_peaks.size(), fresh);
    if (lst) begin
      while (held_peaks.size() > 0)
        retire_oldest(1'b0, held_peaks.size() == 1);
    end else if (held_peaks.size() >= pwrf_pkg::DEPTH) begin
      retire_oldest(1'b1, 1'b0);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_beat(input retired_peak_t want);
    check_field("out_mass", want.mass, out_mass);
    check_field("out_intensity", want.inten, out_intensity);
    check_field("out_keep", want.keep, out_keep);
    check_field("out_overflow", want.overflow, out_overflow);
    check_field("out_last_result", want.last, out_last_result);
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == pwrf_pkg::CFG_HALF_WINDOW)
          half_cfg = cfg_data;
        else
          keep_cfg = cfg_data[pwrf_pkg::CNT_W-1:0];
      end
      // check before predicting: a beat can never stem from a peak taken this edge
      if (out_valid && !out_stall) begin
        if (pending_beats.size() == 0) begin
          $error("out_mass: expected no beat, got %h", out_mass);
          errors++;
        end else begin
          check_beat(pending_beats.pop_front());
        end
      end
      if (in_valid && !in_stall) begin
        rank_peak(in_peak_mass, in_peak_intensity, in_last_peak);
        if (typed_now)
          pending_beats[pending_beats.size() - 1] = typed_beat;
      end
    end
  end

  // result side: hold stall for a drawn number of cycles, then take one beat
  initial begin
    int wait_cycles;
    out_stall = 1'b1;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0)
        out_burst = !out_burst;
      wait_cycles = out_burst ? 0 : $urandom_range(0, 17);
      if (wait_cycles > 0) begin
        out_stall = 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send_peak(input logic [pwrf_pkg::MASS_W-1:0] m,
                           input logic signed [pwrf_pkg::INT_W-1:0] p,
                           input logic lst);
    int gap;
    if ($urandom_range(0, 31) == 0)
      in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          = 1'b1;
    in_peak_mass      = m;
    in_peak_intensity = p;
    in_last_peak      = lst;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // drop valid, wait for every outstanding beat, then let the block go quiet
  task automatic settle();
    in_valid = 1'b0;
    while (pending_beats.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_spectrum(input int len);
    longint                            at;
    longint                            lh;
    longint                            step;
    logic [pwrf_pkg::MASS_W-1:0]       m;
    logic signed [pwrf_pkg::INT_W-1:0] p;
    int                                k;
    if ($urandom_range(0, 3) == 0)
      at = $urandom;
    else
      at = $urandom_range(0, 32'h0100_0000);
    for (k = 0; k < len; k++) begin
      lh = half_cfg;
      case ($urandom_range(0, 7))
        0: step = 0;
        1: step = lh;
        2: step = lh + 1;
        3: step = $urandom_range(0, 32'h0003_0000);
        default: step = $urandom % ((lh >> 1) + 1);
      endcase
      at = at + step;
      if (at > MASS_TOP)
        at = MASS_TOP;
      m = at[31:0];
      // now and then a stray mass, out of order
      if ($urandom_range(0, 11) == 0)
        m = $urandom;
      case ($urandom_range(0, 9))
        0: p = 32'sh7FFF_FFFF;
        1: p = 32'sh8000_0000;
        2: p = '0;
        3, 4: p = $urandom;
        default: p = int'($urandom_range(0, 40)) - 8;
      endcase
      send_peak(m, p, k == len - 1);
    end
  endtask

  task automatic run_phase(input logic [31:0] hw, input logic [pwrf_pkg::CNT_W-1:0] kc,
                           input int budget, input int max_len, input int first_len);
    int sent;
    int len;
    settle();
    write_reg(pwrf_pkg::CFG_HALF_WINDOW, hw);
    write_reg(pwrf_pkg::CFG_KEEP_COUNT, kc);
    sent = 0;
    while (sent < budget) begin
      len = (sent == 0 && first_len > 0) ? first_len : $urandom_range(1, max_len);
      send_spectrum(len);
      sent += len;
      if ($urandom_range(0, 7) == 0)
        settle();
    end
  endtask

  function automatic void add_row(input logic [31:0] m, input logic signed [31:0] p,
                                  input logic lst, input bit typed,
                                  input logic [31:0] wm, input logic signed [31:0] wp,
                                  input logic wk, input logic wl);
    stim_row_t r;
    r.mass  = m;
    r.inten = p;
    r.last  = lst;
    r.typed = typed;
    r.want.mass     = wm;
    r.want.inten    = wp;
    r.want.keep     = wk;
    r.want.overflow = 1'b0;
    r.want.last     = wl;
    stim_rows.insert(stim_rows.size(), r);
  endfunction

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_peak_mass      = '0;
    in_peak_intensity = '0;
    in_last_peak      = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = pwrf_pkg::CFG_HALF_WINDOW;
    cfg_data          = '0;

    // reset settings: half window 25.0, keep count 7
    //       mass          intensity      last typed  want mass     want inten    keep last
    add_row(32'h0000_0000, 32'sh7FFF_FFFF, 1, 1, 32'h0000_0000, 32'sh7FFF_FFFF, 1, 1);
    add_row(32'hFFFF_FFFF, 32'sh8000_0000, 1, 1, 32'hFFFF_FFFF, 32'sh8000_0000, 0, 1);
    add_row(32'h0064_0000, 32'sh0000_0000, 1, 1, 32'h0064_0000, 32'sh0000_0000, 0, 1);
    // window edges: exactly m + half counts, one lsb beyond retires
    add_row(32'h0064_0000, 32'sd10,        0, 0, '0, '0, 0, 0);
    add_row(32'h007D_0000, 32'sd20,        0, 0, '0, '0, 0, 0);
    add_row(32'h007D_0001, 32'sd5,         0, 1, 32'h0064_0000, 32'sd10, 1, 0);
    add_row(32'h007D_0001, 32'sd5,         0, 0, '0, '0, 0, 0);
    add_row(32'h007D_0001, -32'sd3,        0, 0, '0, '0, 0, 0);
    add_row(32'h0096_0001, 32'sd1,         0, 0, '0, '0, 0, 0);
    add_row(32'h0096_0001, 32'sd1,         1, 1, 32'h0096_0001, 32'sd1, 1, 1);
    // lower mass stuck behind the head
    add_row(32'h01F4_0000, 32'sd50,        0, 0, '0, '0, 0, 0);
    add_row(32'h0190_0000, 32'sd60,        0, 0, '0, '0, 0, 0);
    add_row(32'h0258_0000, 32'sd70,        0, 0, '0, '0, 0, 0);
    // one mass, nine intensities: the weakest counts saturate
    add_row(32'h03E8_0000, 32'sd1,         0, 0, '0, '0, 0, 0);
    add_row(32'h03E8_0000, 32'sd2,         0, 0, '0, '0, 0, 0);
    add_row(32'h03E8_0000, 32'sd3,         0, 0, '0, '0, 0, 0);
    add_row(32'h03E8_0000, 32'sd4,         0, 0, '0, '0, 0, 0);
    add_row(32'h03E8_0000, 32'sd5,         0, 0, '0, '0, 0, 0);
    add_row(32'h03E8_0000, 32'sd6,         0, 0, '0, '0, 0, 0);
    add_row(32'h03E8_0000, 32'sd7,         0, 0, '0, '0, 0, 0);
    add_row(32'h03E8_0000, 32'sd8,         0, 0, '0, '0, 0, 0);
    add_row(32'h03E8_0000, 32'sd9,         1, 1, 32'h03E8_0000, 32'sd9, 1, 1);
    // top of the mass range: window sums need the carry bit
    add_row(32'hFFFF_0000, 32'sd5,         0, 0, '0, '0, 0, 0);
    add_row(32'hFFFF_FFFF, 32'sd6,         1, 1, 32'hFFFF_FFFF, 32'sd6, 1, 1);

    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_rows[r]) begin
      typed_now  = stim_rows[r].typed;
      typed_beat = stim_rows[r].want;
      send_peak(stim_rows[r].mass, stim_rows[r].inten, stim_rows[r].last);
    end
    typed_now = 1'b0;

    run_phase(32'h0000_0000, 4'd1, 45, 12, 0);
    // widest window never retires: a long spectrum overflows the store
    run_phase(32'hFFFF_FFFF, 4'd15, 75, 20, 70);
    run_phase(32'h000A_0000, 4'd0, 45, 16, 0);
    run_phase(32'h0002_0000, 4'd3, 45, 16, 0);
    run_phase($urandom_range(0, 32'h0040_0000),
              pwrf_pkg::CNT_W'($urandom_range(1, 15)), 50, 24, 0);
    run_phase($urandom, pwrf_pkg::CNT_W'($urandom_range(0, 15)), 30, 16, 0);
    run_phase(32'd1638400, 4'd7, 40, 16, 0);
    settle();

    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
